### rtl/ps2sc_pkg.sv
// Package for the PS/2 scan code set 2 decoder.
// Holds key code constants, prefix bytes, the result struct and the lookup functions.
// No dependencies.
`default_nettype none

package ps2sc_pkg;

	localparam logic [7:0] BYTE_EXT   = 8'hE0;
	localparam logic [7:0] BYTE_BREAK = 8'hF0;
	localparam logic [7:0] BASE_LIMIT = 8'h84;
	localparam logic [7:0] KEY_NONE   = 8'h00;

	localparam logic [7:0] KEY_F9     = 8'h80;
	localparam logic [7:0] KEY_F5     = 8'h81;
	localparam logic [7:0] KEY_F3     = 8'h82;
	localparam logic [7:0] KEY_F1     = 8'h83;
	localparam logic [7:0] KEY_F2     = 8'h84;
	localparam logic [7:0] KEY_F12    = 8'h85;
	localparam logic [7:0] KEY_F10    = 8'h86;
	localparam logic [7:0] KEY_F8     = 8'h87;
	localparam logic [7:0] KEY_F6     = 8'h88;
	localparam logic [7:0] KEY_F4     = 8'h89;
	localparam logic [7:0] KEY_TAB    = 8'h8A;
	localparam logic [7:0] KEY_LALT   = 8'h8B;
	localparam logic [7:0] KEY_LSHIFT = 8'h8C;
	localparam logic [7:0] KEY_LCTRL  = 8'h8D;
	localparam logic [7:0] KEY_CAPS   = 8'h8E;
	localparam logic [7:0] KEY_RSHIFT = 8'h8F;
	localparam logic [7:0] KEY_ENTER  = 8'h90;
	localparam logic [7:0] KEY_BKSP   = 8'h91;
	localparam logic [7:0] KEY_LEFT   = 8'h92;
	localparam logic [7:0] KEY_DOWN   = 8'h93;
	localparam logic [7:0] KEY_RIGHT  = 8'h94;
	localparam logic [7:0] KEY_UP     = 8'h95;
	localparam logic [7:0] KEY_ESC    = 8'h96;
	localparam logic [7:0] KEY_NUMLK  = 8'h97;
	localparam logic [7:0] KEY_F11    = 8'h98;
	localparam logic [7:0] KEY_SCRLK  = 8'h99;
	localparam logic [7:0] KEY_F7     = 8'h9A;
	localparam logic [7:0] KEY_RALT   = 8'h9B;
	localparam logic [7:0] KEY_RCTRL  = 8'h9C;
	localparam logic [7:0] KEY_LCMD   = 8'h9D;
	localparam logic [7:0] KEY_RCMD   = 8'h9E;
	localparam logic [7:0] KEY_END    = 8'h9F;
	localparam logic [7:0] KEY_HOME   = 8'hA0;
	localparam logic [7:0] KEY_INS    = 8'hA1;
	localparam logic [7:0] KEY_DEL    = 8'hA2;
	localparam logic [7:0] KEY_PGDN   = 8'hA3;
	localparam logic [7:0] KEY_PGUP   = 8'hA4;

	// modifier bit positions
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_CAPS   = 2;
	localparam int MOD_LCTRL  = 3;
	localparam int MOD_RCTRL  = 4;
	localparam int MOD_LALT   = 5;
	localparam int MOD_RALT   = 6;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
		logic       pressed;
		logic [6:0] mods;
	} key_result_t;

	function automatic logic [7:0] base_lookup(input logic [7:0] b);
		logic [7:0] k;
		k = KEY_NONE;
		case (b)
			8'h01: k = KEY_F9;
			8'h03: k = KEY_F5;
			8'h04: k = KEY_F3;
			8'h05: k = KEY_F1;
			8'h06: k = KEY_F2;
			8'h07: k = KEY_F12;
			8'h09: k = KEY_F10;
			8'h0A: k = KEY_F8;
			8'h0B: k = KEY_F6;
			8'h0C: k = KEY_F4;
			8'h0D: k = KEY_TAB;
			8'h0E: k = 8'h60;
			8'h11: k = KEY_LALT;
			8'h12: k = KEY_LSHIFT;
			8'h14: k = KEY_LCTRL;
			8'h15: k = "q";
			8'h16: k = "1";
			8'h1A: k = "z";
			8'h1B: k = "s";
			8'h1C: k = "a";
			8'h1D: k = "w";
			8'h1E: k = "2";
			8'h21: k = "c";
			8'h22: k = "x";
			8'h23: k = "d";
			8'h24: k = "e";
			8'h25: k = "4";
			8'h26: k = "3";
			8'h29: k = 8'h20;
			8'h2A: k = "v";
			8'h2B: k = "f";
			8'h2C: k = "t";
			8'h2D: k = "r";
			8'h2E: k = "5";
			8'h31: k = "n";
			8'h32: k = "b";
			8'h33: k = "h";
			8'h34: k = "g";
			8'h35: k = "y";
			8'h36: k = "6";
			8'h3A: k = "m";
			8'h3B: k = "j";
			8'h3C: k = "u";
			8'h3D: k = "7";
			8'h3E: k = "8";
			8'h41: k = ",";
			8'h42: k = "k";
			8'h43: k = "i";
			8'h44: k = "o";
			8'h45: k = "0";
			8'h46: k = "9";
			8'h49: k = ".";
			8'h4A: k = "/";
			8'h4B: k = "l";
			8'h4C: k = ";";
			8'h4D: k = "p";
			8'h4E: k = "-";
			8'h52: k = 8'h27;
			8'h54: k = "[";
			8'h55: k = "=";
			8'h58: k = KEY_CAPS;
			8'h59: k = KEY_RSHIFT;
			8'h5A: k = KEY_ENTER;
			8'h5B: k = "]";
			8'h5D: k = 8'h5C;
			8'h66: k = KEY_BKSP;
			8'h69: k = "1";
			8'h6B: k = KEY_LEFT;
			8'h6C: k = "7";
			8'h70: k = "0";
			8'h71: k = ".";
			8'h72: k = KEY_DOWN;
			8'h73: k = "5";
			8'h74: k = KEY_RIGHT;
			8'h75: k = KEY_UP;
			8'h76: k = KEY_ESC;
			8'h77: k = KEY_NUMLK;
			8'h78: k = KEY_F11;
			8'h79: k = "+";
			8'h7A: k = "3";
			8'h7B: k = "-";
			8'h7C: k = "*";
			8'h7D: k = "9";
			8'h7E: k = KEY_SCRLK;
			8'h83: k = KEY_F7;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] ext_lookup(input logic [7:0] b);
		logic [7:0] k;
		k = KEY_NONE;
		case (b)
			8'h11: k = KEY_RALT;
			8'h14: k = KEY_RCTRL;
			8'h1F: k = KEY_LCMD;
			8'h27: k = KEY_RCMD;
			8'h4A: k = "/";
			8'h5A: k = KEY_ENTER;
			8'h69: k = KEY_END;
			8'h6B: k = KEY_LEFT;
			8'h6C: k = KEY_HOME;
			8'h70: k = KEY_INS;
			8'h71: k = KEY_DEL;
			8'h72: k = KEY_DOWN;
			8'h74: k = KEY_RIGHT;
			8'h75: k = KEY_UP;
			8'h7A: k = KEY_PGDN;
			8'h7D: k = KEY_PGUP;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

### rtl/ps2_scancode_decoder_unit.sv
// Top level of the PS/2 scan code set 2 decoder: input register, decoder, result register.
// Depends on ps2sc_pkg and ps2sc_decode.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+-------------------------------------
//   in      | byte_valid | byte_stall | scan_byte
//   out     | key_valid  | key_stall  | key_code, key_pressed, modifier_bits
//
// One byte per cycle while not stalled; a result is registered behind the input register.
// The decode of the registered byte and the prefix/modifier update sit in one cycle.
// Reset clears the prefix flags, the modifiers and both valid bits.
// A stalled result holds; the input register fills behind it, then byte_stall rises.
`default_nettype none

module ps2_scancode_decoder_unit
	import ps2sc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] scan_byte,
	output logic            key_valid,
	input  wire logic       key_stall,
	output logic [7:0]      key_code,
	output logic            key_pressed,
	output logic [6:0]      modifier_bits
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [7:0]  key_code_q;
	logic        key_pressed_q;
	logic [6:0]  modifier_bits_q;
	logic        advance;
	logic        fire;
	logic        accept;
	key_result_t result;

	assign advance    = !out_valid_q || !key_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= scan_byte;
		end
	end

	ps2sc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.scan_byte (byte_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && result.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && result.hit) begin
			key_code_q      <= result.code;
			key_pressed_q   <= result.pressed;
			modifier_bits_q <= result.mods;
		end
	end

	assign key_valid     = out_valid_q;
	assign key_code      = key_code_q;
	assign key_pressed   = key_pressed_q;
	assign modifier_bits = modifier_bits_q;

endmodule

`default_nettype wire

### rtl/ps2sc_decode.sv
// Scan byte decoder: prefix flags, modifier register and key lookup.
// Depends on ps2sc_pkg.
`default_nettype none

module ps2sc_decode
	import ps2sc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  scan_byte,
	output key_result_t      result
);

	logic       ext_q;
	logic       rel_q;
	logic [6:0] mods_q;
	logic       ext_d;
	logic       rel_d;
	logic [6:0] mods_d;
	logic [7:0] code;
	logic       make;

	always_comb begin
		ext_d = ext_q;
		rel_d = rel_q;
		code  = KEY_NONE;
		make  = 1'b0;
		if (ext_q) begin
			make = !rel_q;
			if (scan_byte == BYTE_BREAK) begin
				ext_d = 1'b1;
				rel_d = 1'b1;
			end else begin
				ext_d = 1'b0;
				rel_d = 1'b0;
				code  = ext_lookup(scan_byte);
			end
		end else if (scan_byte < BASE_LIMIT) begin
			make  = !rel_q;
			ext_d = 1'b0;
			rel_d = 1'b0;
			code  = base_lookup(scan_byte);
		end else if (scan_byte == BYTE_EXT) begin
			ext_d = 1'b1;
		end else if (scan_byte == BYTE_BREAK) begin
			rel_d = 1'b1;
		end
	end

	always_comb begin
		mods_d = mods_q;
		unique case (code)
			KEY_LSHIFT: mods_d[MOD_LSHIFT] = make;
			KEY_RSHIFT: mods_d[MOD_RSHIFT] = make;
			KEY_CAPS:   mods_d[MOD_CAPS]   = mods_q[MOD_CAPS] ^ make;
			KEY_LCTRL:  mods_d[MOD_LCTRL]  = make;
			KEY_RCTRL:  mods_d[MOD_RCTRL]  = make;
			KEY_LALT:   mods_d[MOD_LALT]   = make;
			KEY_RALT:   mods_d[MOD_RALT]   = make;
			default:    mods_d = mods_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			rel_q  <= 1'b0;
			mods_q <= '0;
		end else if (fire) begin
			ext_q  <= ext_d;
			rel_q  <= rel_d;
			mods_q <= mods_d;
		end
	end

	assign result.hit     = (code != KEY_NONE);
	assign result.code    = code;
	assign result.pressed = make;
	assign result.mods    = mods_d;

endmodule

`default_nettype wire
